// ===== rtl/fbfla_pkg.sv =====
package fbfla_pkg;

  localparam int unsigned CHUNKS      = 64;
  localparam int unsigned CHUNK_BYTES = 8;

  localparam int unsigned IDX_W       = $clog2(CHUNKS);
  localparam int unsigned LINK_W      = $clog2(CHUNKS + 1);
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned CHUNK_SHIFT = $clog2(CHUNK_BYTES);
  localparam int unsigned OFS_IN_W    = 10;
  localparam int unsigned OFS_OUT_W   = 9;
  localparam int unsigned STATUS_W    = 2;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_BAD_OFFSET = 2'd2,
    STAT_FULL       = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  addr;
    logic [LINK_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== rtl/fbfla_if.sv =====
interface fbfla_req_if;
  import fbfla_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [OFS_IN_W-1:0] chunk_offset_in;

  modport source (output valid, output cmd, output chunk_offset_in, input ready);
  modport sink   (input valid, input cmd, input chunk_offset_in, output ready);
endinterface

interface fbfla_rsp_if;
  import fbfla_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OFS_OUT_W-1:0] chunk_offset_out;
  logic [CNT_W-1:0]     free_count;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, output chunk_offset_out, output free_count, output status,
                  input ready);
  modport sink   (input valid, input chunk_offset_out, input free_count, input status,
                  output ready);
endinterface

// ===== rtl/fixed_block_free_list_allocator.sv =====
// channel | dir | fields                                   | handshake
// req_i   | in  | cmd, chunk_offset_in                     | valid/ready
// rsp_o   | out | chunk_offset_out, free_count, status     | valid/ready
//
// Allocate issues the head link read at accept and registers the response from ST_READ;
// free and every error response are registered at accept, where the link write happens.
// Reset: head 0, all chunks free; per-entry written bits make unwritten links
// read as index plus one, so no clearing pass is needed.
// A full output register stalls intake until the response is taken.
module fixed_block_free_list_allocator
  import fbfla_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fbfla_req_if.sink   req_i,
  fbfla_rsp_if.source rsp_o
);

  mem_req_t          mem_req;
  logic [LINK_W-1:0] mem_rdata;

  fbfla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  fbfla_link_mem u_link_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== rtl/fbfla_link_mem.sv =====
module fbfla_link_mem
  import fbfla_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mem_req_t          req_i,
  output logic [LINK_W-1:0] rdata_o
);

  logic [LINK_W-1:0] mem [CHUNKS];
  logic [CHUNKS-1:0] written_q;
  logic [LINK_W-1:0] rdata_q;
  logic              rd_hit_q;
  logic [IDX_W-1:0]  rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q   <= mem[req_i.addr];
      rd_addr_q <= req_i.addr;
    end
  end

  // unwritten entries read as their reset link, index plus one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_hit_q <= written_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rd_hit_q ? rdata_q : (LINK_W'(rd_addr_q) + LINK_W'(1));

endmodule

// ===== rtl/fbfla_ctrl.sv =====
module fbfla_ctrl
  import fbfla_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  fbfla_req_if.sink         req_i,
  fbfla_rsp_if.source       rsp_o,
  output mem_req_t          mem_req_o,
  input  logic [LINK_W-1:0] mem_rdata_i
);

  localparam logic [OFS_IN_W:0] PoolBytes = (OFS_IN_W + 1)'(CHUNKS * CHUNK_BYTES);

  state_e               state_q, state_d;
  logic [LINK_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  logic [OFS_OUT_W-1:0] out_ofs_q, out_ofs_d;
  logic [CNT_W-1:0]     out_cnt_q, out_cnt_d;
  status_e              out_stat_q, out_stat_d;

  logic             out_free;
  logic             accept;
  logic             pool_empty;
  logic             pool_full;
  logic             bad_ofs;
  logic [IDX_W-1:0] free_idx;

  assign out_free   = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept     = req_i.valid && req_i.ready;

  assign pool_empty = (count_q == '0) || (head_q >= LINK_W'(CHUNKS));
  assign pool_full  = (count_q >= CNT_W'(CHUNKS));
  assign bad_ofs    = ((OFS_IN_W + 1)'(req_i.chunk_offset_in) >= PoolBytes) ||
                      (req_i.chunk_offset_in[CHUNK_SHIFT-1:0] != '0);
  assign free_idx   = req_i.chunk_offset_in[CHUNK_SHIFT +: IDX_W];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_i.cmd == CMD_ALLOC) && !pool_empty) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_ofs_d   = out_ofs_q;
    out_cnt_d   = out_cnt_q;
    out_stat_d  = out_stat_q;
    mem_req_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.cmd == CMD_ALLOC) begin
            if (pool_empty) begin
              out_valid_d = 1'b1;
              out_ofs_d   = '0;
              out_cnt_d   = count_q;
              out_stat_d  = STAT_EMPTY;
            end else begin
              mem_req_o.rd_en = 1'b1;
              mem_req_o.addr  = head_q[IDX_W-1:0];
            end
          end else begin
            out_valid_d = 1'b1;
            out_ofs_d   = '0;
            if (pool_full) begin
              out_cnt_d  = count_q;
              out_stat_d = STAT_FULL;
            end else if (bad_ofs) begin
              out_cnt_d  = count_q;
              out_stat_d = STAT_BAD_OFFSET;
            end else begin
              mem_req_o.wr_en = 1'b1;
              mem_req_o.addr  = free_idx;
              mem_req_o.wdata = head_q;
              head_d          = LINK_W'(free_idx);
              count_d         = count_q + CNT_W'(1);
              out_cnt_d       = count_q + CNT_W'(1);
              out_stat_d      = STAT_OK;
            end
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          head_d      = mem_rdata_i;
          count_d     = count_q - CNT_W'(1);
          out_valid_d = 1'b1;
          out_ofs_d   = {head_q[IDX_W-1:0], {CHUNK_SHIFT{1'b0}}};
          out_cnt_d   = count_q - CNT_W'(1);
          out_stat_d  = STAT_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= CNT_W'(CHUNKS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ofs_q  <= out_ofs_d;
    out_cnt_q  <= out_cnt_d;
    out_stat_q <= out_stat_d;
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.chunk_offset_out = out_ofs_q;
  assign rsp_o.free_count       = out_cnt_q;
  assign rsp_o.status           = out_stat_q;

endmodule

// ===== tb/testbench.sv =====
module testbench
  import fbfla_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_CHECK   = 0;
  localparam int SIDE_PLAN    = 1;
  localparam int RANDOM_ITEMS = 1600;
  localparam int TAIL_ITEMS   = 80;
  localparam int SETTLE_CYC   = 20;

  typedef struct packed {
    logic                 hold;
    cmd_e                 op;
    logic [OFS_IN_W-1:0]  ofs;
  } pool_req_t;

  typedef struct packed {
    logic [OFS_OUT_W-1:0] ofs;
    logic [CNT_W-1:0]     cnt;
    status_e              st;
  } chunk_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fbfla_req_if req_if ();
  fbfla_rsp_if rsp_if ();

  fixed_block_free_list_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pool_req_t cur_req  = '0;
  logic      drv_valid = 1'b0;
  logic      take_rdy  = 1'b0;

  assign req_if.valid           = drv_valid;
  assign req_if.cmd             = cur_req.op;
  assign req_if.chunk_offset_in = cur_req.ofs;
  assign rsp_if.ready           = take_rdy;

  // two copies of the pool: one follows accepted items, one plans stimulus
  logic [LINK_W-1:0] pool_link [2][CHUNKS];
  logic [LINK_W-1:0] pool_head [2];
  logic [CNT_W-1:0]  pool_free [2];

  pool_req_t          pend_q[$];
  chunk_reply_t       due_replies[$];
  logic [OFS_OUT_W-1:0] held[$];

  int total_n;
  int sent_n;
  int got_n;
  int fail_n;
  int seen_st [4];
  int burst_left;
  int gap_left;
  int mode;
  int mode_left;
  int phase_cnt;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void pool_clear(input int side);
    for (int i = 0; i < CHUNKS; i++) pool_link[side][i] = LINK_W'(i + 1);
    pool_head[side] = '0;
    pool_free[side] = CNT_W'(CHUNKS);
  endfunction

  function automatic chunk_reply_t pool_step(input int side, input cmd_e op,
                                             input logic [OFS_IN_W-1:0] ofs);
    chunk_reply_t r;
    int unsigned  idx;
    r.ofs = '0;
    r.st  = STAT_OK;
    if (op == CMD_ALLOC) begin
      idx = 32'(pool_head[side]);
      if (pool_free[side] == 0 || idx >= CHUNKS) begin
        r.st = STAT_EMPTY;
      end else begin
        pool_head[side] = pool_link[side][idx];
        pool_free[side] = pool_free[side] - CNT_W'(1);
        r.ofs = OFS_OUT_W'(idx * CHUNK_BYTES);
      end
    end else if (pool_free[side] >= CHUNKS) begin
      r.st = STAT_FULL;
    end else if (ofs >= CHUNKS * CHUNK_BYTES || (ofs % CHUNK_BYTES) != 0) begin
      r.st = STAT_BAD_OFFSET;
    end else begin
      idx = ofs / CHUNK_BYTES;
      pool_link[side][idx] = pool_head[side];
      pool_head[side] = LINK_W'(idx);
      pool_free[side] = pool_free[side] + CNT_W'(1);
    end
    r.cnt = pool_free[side];
    return r;
  endfunction

  task automatic plan_item(input cmd_e op, input logic [OFS_IN_W-1:0] ofs, input bit hold);
    chunk_reply_t r;
    r = pool_step(SIDE_PLAN, op, ofs);
    if (op == CMD_ALLOC && r.st == STAT_OK) held.push_back(r.ofs);
    pend_q.push_back('{hold: hold, op: op, ofs: ofs});
  endtask

  task automatic plan_give_back(input bit hold);
    int                   k;
    logic [OFS_OUT_W-1:0] o;
    k = $urandom_range(0, held.size() - 1);
    o = held[k];
    held.delete(k);
    plan_item(CMD_FREE, OFS_IN_W'(o), hold);
  endtask

  // sender: bursts of items separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (drv_valid && req_if.ready) begin
        due_replies.push_back(pool_step(SIDE_CHECK, cur_req.op, cur_req.ofs));
        sent_n++;
      end
      if (!drv_valid || req_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (pend_q.size() != 0 && (!pend_q[0].hold || due_replies.size() == 0)) begin
          cur_req   <= pend_q.pop_front();
          drv_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between modes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_rdy  <= 1'b0;
      mode      = 0;
      mode_left = 0;
      phase_cnt = 0;
    end else begin
      if (rsp_if.valid && take_rdy) begin
        got_n++;
        seen_st[rsp_if.status]++;
        if (due_replies.size() == 0) begin
          $error("unexpected item: chunk_offset_out=%0d free_count=%0d status=%0d",
                 rsp_if.chunk_offset_out, rsp_if.free_count, rsp_if.status);
          fail_n++;
        end else begin
          chunk_reply_t want;
          want = due_replies.pop_front();
          if (rsp_if.chunk_offset_out !== want.ofs) begin
            $error("chunk_offset_out: expected %0d, got %0d", want.ofs, rsp_if.chunk_offset_out);
            fail_n++;
          end
          if (rsp_if.free_count !== want.cnt) begin
            $error("free_count: expected %0d, got %0d", want.cnt, rsp_if.free_count);
            fail_n++;
          end
          if (rsp_if.status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, rsp_if.status);
            fail_n++;
          end
        end
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      phase_cnt++;
      case (mode)
        0: take_rdy <= 1'b1;
        1: take_rdy <= 1'($urandom_range(0, 1));
        2: take_rdy <= ($urandom_range(0, 3) == 0);
        default: take_rdy <= (phase_cnt % 3 != 0);
      endcase
    end
  end

  initial begin
    int                  n;
    int                  phase_len;
    int                  alloc_pct;
    logic [OFS_IN_W-1:0] junk;
    logic [OFS_OUT_W-1:0] twice;

    pool_clear(SIDE_CHECK);
    pool_clear(SIDE_PLAN);

    // directed: full pool, offset limits, misalignment, round trip
    plan_item(CMD_FREE, '0, 1'b0);
    plan_item(CMD_FREE, '1, 1'b0);
    plan_item(CMD_ALLOC, '1, 1'b0);
    plan_item(CMD_ALLOC, '0, 1'b0);
    plan_item(CMD_FREE, OFS_IN_W'(CHUNKS * CHUNK_BYTES), 1'b0);
    plan_item(CMD_FREE, OFS_IN_W'(1016), 1'b0);
    plan_item(CMD_FREE, OFS_IN_W'(3), 1'b0);
    plan_item(CMD_FREE, OFS_IN_W'(4), 1'b0);
    plan_item(CMD_FREE, OFS_IN_W'(CHUNKS * CHUNK_BYTES - 1), 1'b0);
    plan_give_back(1'b0);
    plan_item(CMD_ALLOC, OFS_IN_W'(512), 1'b0);
    plan_give_back(1'b0);
    plan_give_back(1'b0);
    plan_item(CMD_FREE, OFS_IN_W'((CHUNKS - 1) * CHUNK_BYTES), 1'b0);

    // mostly well-formed traffic with some junk frees; phases lean toward alloc, free or neither
    n = 0;
    while (n < RANDOM_ITEMS) begin
      phase_len = $urandom_range(16, 96);
      case ($urandom_range(0, 2))
        0: alloc_pct = 85;
        1: alloc_pct = 50;
        default: alloc_pct = 15;
      endcase
      for (int i = 0; i < phase_len && n < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          plan_item(CMD_ALLOC, OFS_IN_W'($urandom_range(0, 1023)), n == 0 || n == RANDOM_ITEMS / 2);
        end else if ($urandom_range(0, 9) == 0 || held.size() == 0) begin
          junk = OFS_IN_W'($urandom_range(0, 1023));
          if (junk < CHUNKS * CHUNK_BYTES && junk % CHUNK_BYTES == 0) junk[0] = 1'b1;
          plan_item(CMD_FREE, junk, n == 0 || n == RANDOM_ITEMS / 2);
        end else begin
          plan_give_back(n == 0 || n == RANDOM_ITEMS / 2);
        end
        n++;
      end
    end

    // double free, then loose traffic over a corrupted list
    plan_item(CMD_ALLOC, '0, 1'b0);
    plan_item(CMD_ALLOC, '0, 1'b0);
    twice = held[$];
    plan_item(CMD_FREE, OFS_IN_W'(twice), 1'b0);
    plan_item(CMD_FREE, OFS_IN_W'(twice), 1'b0);
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      if ($urandom_range(0, 1) == 0)
        plan_item(CMD_ALLOC, OFS_IN_W'($urandom_range(0, 1023)), 1'b0);
      else
        plan_item(CMD_FREE, OFS_IN_W'($urandom_range(0, CHUNKS - 1) * CHUNK_BYTES), 1'b0);
    end
    total_n = pend_q.size();

    while (sent_n < total_n) @(posedge clk_i);
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("Covered %0d requests and %0d results: ok %0d, pool empty %0d, bad offset %0d,",
             total_n, got_n, seen_st[STAT_OK], seen_st[STAT_EMPTY], seen_st[STAT_BAD_OFFSET]);
    $display("already full %0d, with double frees on a corrupted list at the end.",
             seen_st[STAT_FULL]);
    if (fail_n == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
